### hdl/cbe_pkg.sv
`default_nettype none

package cbe_pkg;

    // Configuration port geometry: eight 32-bit registers at byte addresses 4*i.
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int IDX_LSB   = 2;

    // Two axes, four control points per axis.
    localparam int NUM_AXES  = 2;
    localparam int NUM_CTRL  = 4;

    // Pipeline layout: one input stage, three cells of three stages each,
    // one output stage.
    localparam int CELL_STAGES = 3;
    localparam int NUM_LEVELS  = 3;
    localparam int NUM_STAGES  = 2 + CELL_STAGES * NUM_LEVELS;
    localparam int OUT_STAGE   = NUM_STAGES - 1;

    typedef enum logic [2:0] {
        REG_CTRL0_X = 3'd0,
        REG_CTRL0_Y = 3'd1,
        REG_CTRL1_X = 3'd2,
        REG_CTRL1_Y = 3'd3,
        REG_CTRL2_X = 3'd4,
        REG_CTRL2_Y = 3'd5,
        REG_CTRL3_X = 3'd6,
        REG_CTRL3_Y = 3'd7
    } reg_idx_t;

    // Load enables for the three register stages inside one cell.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } cell_en_t;

    // Index of the first pipeline stage of a de Casteljau level (1 to 3).
    function automatic int level_base(input int level);
        return 1 + CELL_STAGES * (level - 1);
    endfunction

endpackage

`default_nettype wire

### hdl/cbe_lerp_cell.sv
`default_nettype none

// One de Casteljau step: out = a * (2^F - t) + b * t, computed exactly as
// a * 2^F + (b - a) * t. The result is known to fit OUT_W bits, so all sums
// are taken modulo 2^OUT_W.
module cbe_lerp_cell #(
    parameter int IN_W = 16,
    parameter int F    = 16
) (
    input  wire                        clk,
    input  wire cbe_pkg::cell_en_t     en,
    input  wire logic signed [IN_W-1:0] a_in,
    input  wire logic signed [IN_W-1:0] b_in,
    input  wire logic [F:0]             t_in,
    output logic signed [IN_W+F-1:0]    val_out,
    output logic signed [IN_W:0]        diff_out,
    output logic [F:0]                  t_out
);

    localparam int DW    = IN_W + 1;
    localparam int H     = (DW + 1) / 2;
    localparam int HW    = DW - H;
    localparam int PLW   = H + F + 1;
    localparam int PHW   = HW + F + 2;
    localparam int SW    = DW + F + 2;
    localparam int OUT_W = IN_W + F;

    logic signed [IN_W-1:0] a1_reg, a2_reg;
    logic signed [DW-1:0]   d1_reg, d2_reg, d3_reg;
    logic [F:0]             t1_reg, t2_reg, t3_reg;
    logic [PLW-1:0]         pl_reg;
    logic signed [PHW-1:0]  ph_reg;
    logic signed [OUT_W-1:0] val_reg;

    logic [SW-1:0] a_ext;
    logic [SW-1:0] pl_ext;
    logic [SW-1:0] ph_sh;
    logic [SW-1:0] sum;

    // Stage 1: difference of the two neighbors.
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            a1_reg <= a_in;
            d1_reg <= $signed({b_in[IN_W-1], b_in}) - $signed({a_in[IN_W-1], a_in});
            t1_reg <= t_in;
        end
    end

    // Stage 2: the difference times t, split in two partial products.
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            a2_reg <= a1_reg;
            d2_reg <= d1_reg;
            t2_reg <= t1_reg;
            pl_reg <= d1_reg[H-1:0] * t1_reg;
            ph_reg <= $signed(d1_reg[DW-1:H]) * $signed({1'b0, t1_reg});
        end
    end

    // Stage 3: combine the partial products with the scaled left neighbor.
    assign a_ext  = {{(SW-IN_W-F){a2_reg[IN_W-1]}}, a2_reg, {F{1'b0}}};
    assign pl_ext = {{(SW-PLW){1'b0}}, pl_reg};
    assign ph_sh  = {ph_reg, {H{1'b0}}};
    assign sum    = a_ext + ph_sh + pl_ext;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            val_reg <= sum[OUT_W-1:0];
            d3_reg  <= d2_reg;
            t3_reg  <= t2_reg;
        end
    end

    assign val_out  = val_reg;
    assign diff_out = d3_reg;
    assign t_out    = t3_reg;

endmodule

`default_nettype wire

### hdl/cbe_pipe_ctrl.sv
`default_nettype none

// Valid bits for every pipeline stage. A stage may load when it is empty or
// when everything after it can move, so bubbles close up under a stall.
module cbe_pipe_ctrl (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    input  wire                             out_ready,
    output logic                            in_ready,
    output logic                            out_valid,
    output logic [cbe_pkg::NUM_STAGES-1:0]  stage_en
);

    localparam int NS = cbe_pkg::NUM_STAGES;

    logic [NS-1:0] valid_reg, valid_next;
    logic [NS-1:0] ready;
    logic [NS-1:0] prev_valid;

    genvar j;
    generate
        for (j = 0; j < NS; j++)
        begin : g_ready
            assign ready[j] = out_ready | ~(&valid_reg[NS-1:j]);
        end
    endgenerate

    assign prev_valid = {valid_reg[NS-2:0], in_valid};
    assign stage_en   = ready & prev_valid;

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            valid_next[i] = ready[i] ? prev_valid[i] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = ready[0];
    assign out_valid = valid_reg[NS-1];

endmodule

`default_nettype wire

### hdl/cbe_round.sv
`default_nettype none

// Output stage: rounds the point and the tripled derivative to nearest with
// ties upward, and flags a derivative that is exactly zero before rounding.
module cbe_round #(
    parameter int C = 16,
    parameter int F = 16
) (
    input  wire                               clk,
    input  wire                               en,
    input  wire logic signed [C+3*F-1:0]      pnum_x,
    input  wire logic signed [C+3*F-1:0]      pnum_y,
    input  wire logic signed [C+2*F:0]        dnum_x,
    input  wire logic signed [C+2*F:0]        dnum_y,
    output logic signed [C-1:0]               point_x,
    output logic signed [C-1:0]               point_y,
    output logic signed [C+2:0]               deriv_x,
    output logic signed [C+2:0]               deriv_y,
    output logic                              deriv_zero
);

    localparam int PW  = C + 3 * F;
    localparam int DNW = C + 2 * F + 1;
    localparam int TW  = DNW + 2;

    localparam logic [PW-1:0] P_HALF = {{C{1'b0}}, 1'b1, {(3*F-1){1'b0}}};
    localparam logic [TW-1:0] D_HALF = {{(C+3){1'b0}}, 1'b1, {(2*F-1){1'b0}}};

    logic [PW-1:0] px_sum, py_sum;
    logic [TW-1:0] dx_ext, dy_ext, dx_sum, dy_sum;

    logic signed [C-1:0]   point_x_reg, point_y_reg;
    logic signed [C+2:0]   deriv_x_reg, deriv_y_reg;
    logic                  zero_reg;

    assign px_sum = pnum_x + P_HALF;
    assign py_sum = pnum_y + P_HALF;

    assign dx_ext = {{2{dnum_x[DNW-1]}}, dnum_x};
    assign dy_ext = {{2{dnum_y[DNW-1]}}, dnum_y};
    assign dx_sum = dx_ext + {dx_ext[TW-2:0], 1'b0} + D_HALF;
    assign dy_sum = dy_ext + {dy_ext[TW-2:0], 1'b0} + D_HALF;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            point_x_reg <= px_sum[PW-1:3*F];
            point_y_reg <= py_sum[PW-1:3*F];
            deriv_x_reg <= dx_sum[TW-1:2*F];
            deriv_y_reg <= dy_sum[TW-1:2*F];
            zero_reg    <= (dnum_x == '0) && (dnum_y == '0);
        end
    end

    assign point_x    = point_x_reg;
    assign point_y    = point_y_reg;
    assign deriv_x    = deriv_x_reg;
    assign deriv_y    = deriv_y_reg;
    assign deriv_zero = zero_reg;

endmodule

`default_nettype wire

### hdl/cubic_bezier_evaluator.sv
`default_nettype none

// Cubic Bezier curve evaluator. The four 2-D control points are written over
// the APB port (ctrl0_x at byte address 0, ctrl0_y at 4, up to ctrl3_y at 28;
// the low COORD_BITS bits of the data are taken, and reads return them sign
// extended). Each word on the t channel carries t in unsigned Q1.T_FRAC_BITS
// (values above 1.0 are treated as 1.0), and each word on the result channel
// carries the rounded curve point, the rounded first derivative including
// its factor of three, and a flag that is set when that derivative is exactly
// zero before rounding. The block accepts one word per cycle and returns one
// result word per cycle for as long as the result side is ready. The
// pipeline is the chain of three lerp cells, one per de Casteljau level,
// each taking three stages (difference, split multiply, combine), plus an
// input register and a rounding register. A stall on the result side holds
// the words in place, and empty stages keep filling, so up to eleven words
// can be in flight. Control points must be written only while no word is
// in the pipeline.
module cubic_bezier_evaluator #(
    parameter int COORD_BITS  = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,

    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire [cbe_pkg::ADDR_W-1:0]            paddr,
    input  wire [cbe_pkg::DATA_W-1:0]            pwdata,
    output logic [cbe_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready,

    input  wire                                  t_valid,
    output logic                                 t_ready,
    input  wire [T_FRAC_BITS:0]                  t_param,

    output logic                                 res_valid,
    input  wire                                  res_ready,
    output logic signed [COORD_BITS-1:0]         point_x,
    output logic signed [COORD_BITS-1:0]         point_y,
    output logic signed [COORD_BITS+2:0]         deriv_x,
    output logic signed [COORD_BITS+2:0]         deriv_y,
    output logic                                 deriv_zero
);

    localparam int C  = COORD_BITS;
    localparam int F  = T_FRAC_BITS;
    localparam int NA = cbe_pkg::NUM_AXES;
    localparam int NC = cbe_pkg::NUM_CTRL;

    localparam int B1 = cbe_pkg::level_base(1);
    localparam int B2 = cbe_pkg::level_base(2);
    localparam int B3 = cbe_pkg::level_base(3);

    // Control point registers, indexed by axis (x first) and point.
    logic signed [C-1:0] ctrl_reg [NA][NC];

    cbe_pkg::reg_idx_t cfg_idx;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_idx   = cbe_pkg::reg_idx_t'(paddr[cbe_pkg::IDX_LSB+2:cbe_pkg::IDX_LSB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NA; a++)
            begin
                for (int p = 0; p < NC; p++)
                begin
                    ctrl_reg[a][p] <= '0;
                end
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                cbe_pkg::REG_CTRL0_X: ctrl_reg[0][0] <= pwdata[C-1:0];
                cbe_pkg::REG_CTRL0_Y: ctrl_reg[1][0] <= pwdata[C-1:0];
                cbe_pkg::REG_CTRL1_X: ctrl_reg[0][1] <= pwdata[C-1:0];
                cbe_pkg::REG_CTRL1_Y: ctrl_reg[1][1] <= pwdata[C-1:0];
                cbe_pkg::REG_CTRL2_X: ctrl_reg[0][2] <= pwdata[C-1:0];
                cbe_pkg::REG_CTRL2_Y: ctrl_reg[1][2] <= pwdata[C-1:0];
                cbe_pkg::REG_CTRL3_X: ctrl_reg[0][3] <= pwdata[C-1:0];
                cbe_pkg::REG_CTRL3_Y: ctrl_reg[1][3] <= pwdata[C-1:0];
                default: ;
            endcase
        end
    end

    // Register readback, sign extended to the bus width.
    always_comb
    begin
        unique case (cfg_idx)
            cbe_pkg::REG_CTRL0_X: prdata = cbe_pkg::DATA_W'(ctrl_reg[0][0]);
            cbe_pkg::REG_CTRL0_Y: prdata = cbe_pkg::DATA_W'(ctrl_reg[1][0]);
            cbe_pkg::REG_CTRL1_X: prdata = cbe_pkg::DATA_W'(ctrl_reg[0][1]);
            cbe_pkg::REG_CTRL1_Y: prdata = cbe_pkg::DATA_W'(ctrl_reg[1][1]);
            cbe_pkg::REG_CTRL2_X: prdata = cbe_pkg::DATA_W'(ctrl_reg[0][2]);
            cbe_pkg::REG_CTRL2_Y: prdata = cbe_pkg::DATA_W'(ctrl_reg[1][2]);
            cbe_pkg::REG_CTRL3_X: prdata = cbe_pkg::DATA_W'(ctrl_reg[0][3]);
            cbe_pkg::REG_CTRL3_Y: prdata = cbe_pkg::DATA_W'(ctrl_reg[1][3]);
            default:              prdata = '0;
        endcase
    end

    // Pipeline handshake control.
    logic [cbe_pkg::NUM_STAGES-1:0] stage_en;

    cbe_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t_valid),
        .out_ready (res_ready),
        .in_ready  (t_ready),
        .out_valid (res_valid),
        .stage_en  (stage_en)
    );

    cbe_pkg::cell_en_t en_l1, en_l2, en_l3;

    assign en_l1 = '{s1: stage_en[B1], s2: stage_en[B1+1], s3: stage_en[B1+2]};
    assign en_l2 = '{s1: stage_en[B2], s2: stage_en[B2+1], s3: stage_en[B2+2]};
    assign en_l3 = '{s1: stage_en[B3], s2: stage_en[B3+1], s3: stage_en[B3+2]};

    // Input stage: t is clamped to 1.0, which is the only legal value with
    // the integer bit set.
    logic [F:0] t_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            t_reg <= t_param[F] ? {1'b1, {F{1'b0}}} : t_param;
        end
    end

    // Cell outputs. Level k values carry k*F fraction bits.
    logic signed [C+F-1:0]   l1_val [NA][3];
    logic signed [C+2*F-1:0] l2_val [NA][2];
    logic signed [C+3*F-1:0] l3_val [NA];
    logic signed [C+2*F:0]   l3_diff [NA];
    logic [F:0]              l1_t;
    logic [F:0]              l2_t;

    genvar ax, ln;
    generate
        for (ax = 0; ax < NA; ax++)
        begin : g_axis
            for (ln = 0; ln < 3; ln++)
            begin : g_l1
                if (ax == 0 && ln == 0)
                begin : g_tap
                    cbe_lerp_cell #(.IN_W(C), .F(F)) u_cell (
                        .clk      (clk),
                        .en       (en_l1),
                        .a_in     (ctrl_reg[ax][ln]),
                        .b_in     (ctrl_reg[ax][ln+1]),
                        .t_in     (t_reg),
                        .val_out  (l1_val[ax][ln]),
                        .diff_out (),
                        .t_out    (l1_t)
                    );
                end
                else
                begin : g_plain
                    cbe_lerp_cell #(.IN_W(C), .F(F)) u_cell (
                        .clk      (clk),
                        .en       (en_l1),
                        .a_in     (ctrl_reg[ax][ln]),
                        .b_in     (ctrl_reg[ax][ln+1]),
                        .t_in     (t_reg),
                        .val_out  (l1_val[ax][ln]),
                        .diff_out (),
                        .t_out    ()
                    );
                end
            end

            for (ln = 0; ln < 2; ln++)
            begin : g_l2
                if (ax == 0 && ln == 0)
                begin : g_tap
                    cbe_lerp_cell #(.IN_W(C+F), .F(F)) u_cell (
                        .clk      (clk),
                        .en       (en_l2),
                        .a_in     (l1_val[ax][ln]),
                        .b_in     (l1_val[ax][ln+1]),
                        .t_in     (l1_t),
                        .val_out  (l2_val[ax][ln]),
                        .diff_out (),
                        .t_out    (l2_t)
                    );
                end
                else
                begin : g_plain
                    cbe_lerp_cell #(.IN_W(C+F), .F(F)) u_cell (
                        .clk      (clk),
                        .en       (en_l2),
                        .a_in     (l1_val[ax][ln]),
                        .b_in     (l1_val[ax][ln+1]),
                        .t_in     (l1_t),
                        .val_out  (l2_val[ax][ln]),
                        .diff_out (),
                        .t_out    ()
                    );
                end
            end

            // The last level's difference of neighbors is the derivative
            // numerator, which it hands on beside the point.
            cbe_lerp_cell #(.IN_W(C+2*F), .F(F)) u_l3 (
                .clk      (clk),
                .en       (en_l3),
                .a_in     (l2_val[ax][0]),
                .b_in     (l2_val[ax][1]),
                .t_in     (l2_t),
                .val_out  (l3_val[ax]),
                .diff_out (l3_diff[ax]),
                .t_out    ()
            );
        end
    endgenerate

    cbe_round #(.C(C), .F(F)) u_round (
        .clk        (clk),
        .en         (stage_en[cbe_pkg::OUT_STAGE]),
        .pnum_x     (l3_val[0]),
        .pnum_y     (l3_val[1]),
        .dnum_x     (l3_diff[0]),
        .dnum_y     (l3_diff[1]),
        .point_x    (point_x),
        .point_y    (point_y),
        .deriv_x    (deriv_x),
        .deriv_y    (deriv_y),
        .deriv_zero (deriv_zero)
    );

endmodule

`default_nettype wire
